// ===== rtl/core/tbt_pkg.sv =====
// Shared types and widths for the triangle tangent/bitangent core.
// Used by every module under rtl/core; depends on nothing.
package tbt_pkg;

  localparam int POS_W        = 32;  // position and result width
  localparam int UV_W         = 16;  // texture coordinate width
  localparam int UV_FRAC_BITS = 12;  // fraction bits of a UV value
  localparam int DP_W         = POS_W + 1;       // position delta
  localparam int DUV_W        = UV_W + 1;        // UV delta
  localparam int PROD_W       = DP_W + DUV_W;    // one product
  localparam int NUM_W        = PROD_W + 1;      // difference of two products
  localparam int DET_W        = 2 * DUV_W + 1;   // UV determinant
  localparam int Q_W          = 32;              // quotients at or above 2^Q_W saturate
  localparam int EXT_W        = NUM_W + UV_FRAC_BITS;
  localparam int HI_W         = EXT_W - Q_W;
  localparam int DIV_STEPS    = Q_W;
  localparam int STEP_CNT_W   = $clog2(DIV_STEPS);
  localparam int N_LANES      = 6;
  localparam int LANE_W       = $clog2(N_LANES);
  localparam int N_STEPS      = 2 * (N_LANES + 1);  // products per triangle
  localparam int MUL_CNT_W    = $clog2(N_STEPS + 1);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [POS_W-1:0] OUT_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] OUT_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // One triangle's deltas, handed from the front to the back.
  typedef struct packed {
    logic [DP_W-1:0]  dp1_x;
    logic [DP_W-1:0]  dp1_y;
    logic [DP_W-1:0]  dp1_z;
    logic [DP_W-1:0]  dp2_x;
    logic [DP_W-1:0]  dp2_y;
    logic [DP_W-1:0]  dp2_z;
    logic [DUV_W-1:0] du1;
    logic [DUV_W-1:0] dv1;
    logic [DUV_W-1:0] du2;
    logic [DUV_W-1:0] dv2;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/core/tbt_front.sv =====
// Front part: holds the first two vertices of a group and forms the
// triangle deltas on the third one. Depends on tbt_pkg.
module tbt_front import tbt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  input  logic                   in_first_of_mesh,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic signed [POS_W-1:0] in_pos_z,
  input  logic signed [UV_W-1:0]  in_tex_u,
  input  logic signed [UV_W-1:0]  in_tex_v,
  input  logic                   q_full,
  output logic                   job_push,
  output job_t                   job
);

  localparam logic [1:0] SLOT_A = 2'd0;
  localparam logic [1:0] SLOT_B = 2'd1;
  localparam logic [1:0] SLOT_C = 2'd2;

  logic [1:0]       slot_r;
  logic [1:0]       slot;
  logic             accept;
  logic [POS_W-1:0] held_x_r [2];
  logic [POS_W-1:0] held_y_r [2];
  logic [POS_W-1:0] held_z_r [2];
  logic [UV_W-1:0]  held_u_r [2];
  logic [UV_W-1:0]  held_v_r [2];

  assign accept = in_push && !q_full;

  // A mesh start, and the unused fourth code, both begin a new group.
  always_comb begin
    slot = slot_r;
    if (in_first_of_mesh || (slot_r != SLOT_A && slot_r != SLOT_B && slot_r != SLOT_C)) begin
      slot = SLOT_A;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= SLOT_A;
    end else if (accept) begin
      slot_r <= (slot == SLOT_C) ? SLOT_A : slot + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && slot != SLOT_C) begin
      held_x_r[slot[0]] <= in_pos_x;
      held_y_r[slot[0]] <= in_pos_y;
      held_z_r[slot[0]] <= in_pos_z;
      held_u_r[slot[0]] <= in_tex_u;
      held_v_r[slot[0]] <= in_tex_v;
    end
  end

  assign job_push = accept && (slot == SLOT_C);

  assign job.dp1_x = {held_x_r[1][POS_W-1], held_x_r[1]} - {held_x_r[0][POS_W-1], held_x_r[0]};
  assign job.dp1_y = {held_y_r[1][POS_W-1], held_y_r[1]} - {held_y_r[0][POS_W-1], held_y_r[0]};
  assign job.dp1_z = {held_z_r[1][POS_W-1], held_z_r[1]} - {held_z_r[0][POS_W-1], held_z_r[0]};
  assign job.dp2_x = {in_pos_x[POS_W-1], in_pos_x} - {held_x_r[0][POS_W-1], held_x_r[0]};
  assign job.dp2_y = {in_pos_y[POS_W-1], in_pos_y} - {held_y_r[0][POS_W-1], held_y_r[0]};
  assign job.dp2_z = {in_pos_z[POS_W-1], in_pos_z} - {held_z_r[0][POS_W-1], held_z_r[0]};
  assign job.du1   = {held_u_r[1][UV_W-1], held_u_r[1]} - {held_u_r[0][UV_W-1], held_u_r[0]};
  assign job.dv1   = {held_v_r[1][UV_W-1], held_v_r[1]} - {held_v_r[0][UV_W-1], held_v_r[0]};
  assign job.du2   = {in_tex_u[UV_W-1], in_tex_u} - {held_u_r[0][UV_W-1], held_u_r[0]};
  assign job.dv2   = {in_tex_v[UV_W-1], in_tex_v} - {held_v_r[0][UV_W-1], held_v_r[0]};

endmodule

// ===== rtl/core/tbt_queue.sv =====
// Short queue of triangle jobs between the front and the back part.
// Depends on tbt_pkg for job_t and the depth.
module tbt_queue import tbt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_data,
  input  logic    pop,
  output job_t    head,
  output q_stat_t stat
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/tbt_div.sv =====
// One divider lane: num * 2^UV_FRAC_BITS / det, rounded half away from
// zero and saturated, by restoring division one bit a cycle. Uses tbt_pkg.
module tbt_div import tbt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DET_W-1:0] det,
  output logic                    busy,
  output logic [POS_W-1:0]        quo
);

  logic [NUM_W-1:0]      n_mag;
  logic [DET_W-1:0]      d_mag;
  logic [EXT_W-1:0]      n_ext;
  logic [DET_W-1:0]      n_hi;
  logic                  sat_start;
  logic [DET_W-1:0]      rem_r;
  logic [Q_W-1:0]        lo_r;
  logic [Q_W-1:0]        q_r;
  logic [DET_W-1:0]      d_r;
  logic                  neg_r;
  logic                  sat_r;
  logic                  busy_r;
  logic [STEP_CNT_W-1:0] cnt_r;
  logic [DET_W:0]        sh;
  logic [DET_W:0]        diff;
  logic                  ge;
  logic                  rnd;
  logic [Q_W:0]          mag;

  assign n_mag = num[NUM_W-1] ? (~num + 1'b1) : num;
  assign d_mag = det[DET_W-1] ? (~det + 1'b1) : det;
  assign n_ext = {n_mag, {UV_FRAC_BITS{1'b0}}};
  assign n_hi  = {{(DET_W-HI_W){1'b0}}, n_ext[EXT_W-1:Q_W]};
  // The quotient reaches 2^Q_W exactly when the top part already holds det.
  assign sat_start = (n_hi >= d_mag);

  assign sh   = {rem_r, lo_r[Q_W-1]};
  assign diff = sh - {1'b0, d_r};
  assign ge   = (sh >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= !sat_start;
    end else if (busy_r && cnt_r == STEP_CNT_W'(DIV_STEPS - 1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= d_mag;
      neg_r <= num[NUM_W-1] ^ det[DET_W-1];
      sat_r <= sat_start;
      rem_r <= n_hi;
      lo_r  <= n_ext[Q_W-1:0];
      q_r   <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DET_W-1:0] : sh[DET_W-1:0];
      lo_r  <= {lo_r[Q_W-2:0], 1'b0};
      q_r   <= {q_r[Q_W-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign rnd  = ({rem_r, 1'b0} >= {1'b0, d_r});
  assign mag  = {1'b0, q_r} + {{Q_W{1'b0}}, rnd};
  assign busy = busy_r;

  always_comb begin
    if (sat_r || mag[Q_W:POS_W-1] != '0) begin
      quo = neg_r ? OUT_MIN : OUT_MAX;
    end else if (neg_r) begin
      quo = ~mag[POS_W-1:0] + 1'b1;
    end else begin
      quo = mag[POS_W-1:0];
    end
  end

endmodule

// ===== rtl/core/tbt_back.sv =====
// Back part: forms the determinant and six numerators on one shared
// multiplier, runs six divider lanes and holds the result. Uses tbt_pkg, tbt_div.
module tbt_back import tbt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  q_stat_t                 q_stat,
  input  job_t                    q_head,
  output logic                    q_pop,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic signed [POS_W-1:0] out_tangent_x,
  output logic signed [POS_W-1:0] out_tangent_y,
  output logic signed [POS_W-1:0] out_tangent_z,
  output logic signed [POS_W-1:0] out_bitangent_x,
  output logic signed [POS_W-1:0] out_bitangent_y,
  output logic signed [POS_W-1:0] out_bitangent_z,
  output logic                    out_degenerate
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FIN
  } state_t;

  function automatic logic [DP_W-1:0] sext_uv(input logic [DUV_W-1:0] v);
    return {{(DP_W-DUV_W){v[DUV_W-1]}}, v};
  endfunction

  state_t               state_r;
  job_t                 job_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic [MUL_CNT_W-1:0] step;
  logic [DP_W-1:0]      op_a;
  logic [DUV_W-1:0]     op_b;
  logic [PROD_W-1:0]    prod_r;
  logic [PROD_W-1:0]    first_r;
  logic [NUM_W-1:0]     term;
  logic [DET_W-1:0]     det_r;
  logic [NUM_W-1:0]     num_r [N_LANES];
  logic                 deg_r;
  logic                 res_valid_r;
  logic [POS_W-1:0]     res_r [N_LANES];
  logic                 res_deg_r;
  logic                 lane_start;
  logic [N_LANES-1:0]   lane_busy;
  logic [POS_W-1:0]     lane_quo [N_LANES];

  // Pairs of products: determinant, then tangent x/y/z, then bitangent x/y/z.
  always_comb begin
    case (cnt_r)
      4'd0:    begin op_a = sext_uv(job_r.du1); op_b = job_r.dv2; end
      4'd1:    begin op_a = sext_uv(job_r.dv1); op_b = job_r.du2; end
      4'd2:    begin op_a = job_r.dp1_x;        op_b = job_r.dv2; end
      4'd3:    begin op_a = job_r.dp2_x;        op_b = job_r.dv1; end
      4'd4:    begin op_a = job_r.dp1_y;        op_b = job_r.dv2; end
      4'd5:    begin op_a = job_r.dp2_y;        op_b = job_r.dv1; end
      4'd6:    begin op_a = job_r.dp1_z;        op_b = job_r.dv2; end
      4'd7:    begin op_a = job_r.dp2_z;        op_b = job_r.dv1; end
      4'd8:    begin op_a = job_r.dp2_x;        op_b = job_r.du1; end
      4'd9:    begin op_a = job_r.dp1_x;        op_b = job_r.du2; end
      4'd10:   begin op_a = job_r.dp2_y;        op_b = job_r.du1; end
      4'd11:   begin op_a = job_r.dp1_y;        op_b = job_r.du2; end
      4'd12:   begin op_a = job_r.dp2_z;        op_b = job_r.du1; end
      4'd13:   begin op_a = job_r.dp1_z;        op_b = job_r.du2; end
      default: begin op_a = '0;                 op_b = '0;        end
    endcase
  end

  assign step = cnt_r - 1'b1;
  assign term = {first_r[PROD_W-1], first_r} - {prod_r[PROD_W-1], prod_r};

  assign q_pop      = (state_r == ST_IDLE) && !q_stat.empty;
  assign lane_start = (state_r == ST_DIV_GO);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      if (out_pop && res_valid_r) begin
        res_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            job_r   <= q_head;
            cnt_r   <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (cnt_r != MUL_CNT_W'(N_STEPS)) begin
            prod_r <= PROD_W'($signed(op_a) * $signed(op_b));
          end
          // The product issued in the previous cycle is consumed here.
          if (cnt_r != '0) begin
            if (!step[0]) begin
              first_r <= prod_r;
            end else if (step[MUL_CNT_W-1:1] == '0) begin
              det_r <= term[DET_W-1:0];
            end else begin
              num_r[LANE_W'(step[MUL_CNT_W-1:1] - 1'b1)] <= term;
            end
          end
          if (cnt_r == MUL_CNT_W'(N_STEPS)) begin
            deg_r   <= (det_r == '0);
            state_r <= (det_r == '0) ? ST_FIN : ST_DIV_GO;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_DIV_GO: begin
          state_r <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (lane_busy == '0) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!res_valid_r) begin
            for (int i = 0; i < N_LANES; i++) begin
              res_r[i] <= deg_r ? '0 : lane_quo[i];
            end
            res_deg_r   <= deg_r;
            res_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  for (genvar g = 0; g < N_LANES; g++) begin : g_lane
    tbt_div u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (lane_start),
      .num   (num_r[g]),
      .det   (det_r),
      .busy  (lane_busy[g]),
      .quo   (lane_quo[g])
    );
  end

  assign out_empty       = !res_valid_r;
  assign out_tangent_x   = res_r[0];
  assign out_tangent_y   = res_r[1];
  assign out_tangent_z   = res_r[2];
  assign out_bitangent_x = res_r[3];
  assign out_bitangent_y = res_r[4];
  assign out_bitangent_z = res_r[5];
  assign out_degenerate  = res_deg_r;

endmodule

// ===== rtl/core/triangle_tangent_bitangent_core.sv =====
// Top level of the triangle tangent/bitangent core: front, job queue, back.
// Depends on tbt_pkg, tbt_front, tbt_queue, tbt_back.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------
//   in_      | in_push / in_full  | first_of_mesh, pos_x/y/z, tex_u/v
//   out_     | out_pop / out_empty| tangent_x/y/z, bitangent_x/y/z, degenerate
//
// A vertex is taken whenever in_push is high and in_full is low; only the third vertex of a group makes work.
// The back works on one triangle at a time: it takes the job, forms the products
// on the shared multiplier, starts the six one-bit-a-cycle divider lanes, waits on
// them and loads the result once the previous result is popped; a zero determinant
// skips the lanes and goes straight to loading the result.
// The two-entry job queue lets vertices keep coming while the back works and
// while a result waits to be popped. Reset (rst_n low, synchronous) empties
// both sides and restarts grouping; no clearing pass is needed.
module triangle_tangent_bitangent_core import tbt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic                    in_first_of_mesh,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic signed [POS_W-1:0] in_pos_z,
  input  logic signed [UV_W-1:0]  in_tex_u,
  input  logic signed [UV_W-1:0]  in_tex_v,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic signed [POS_W-1:0] out_tangent_x,
  output logic signed [POS_W-1:0] out_tangent_y,
  output logic signed [POS_W-1:0] out_tangent_z,
  output logic signed [POS_W-1:0] out_bitangent_x,
  output logic signed [POS_W-1:0] out_bitangent_y,
  output logic signed [POS_W-1:0] out_bitangent_z,
  output logic                    out_degenerate
);

  q_stat_t q_stat;
  job_t    job;
  job_t    head;
  logic    job_push;
  logic    q_pop;

  assign in_full = q_stat.full;

  tbt_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_first_of_mesh (in_first_of_mesh),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_tex_u         (in_tex_u),
    .in_tex_v         (in_tex_v),
    .q_full           (q_stat.full),
    .job_push         (job_push),
    .job              (job)
  );

  tbt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job),
    .pop       (q_pop),
    .head      (head),
    .stat      (q_stat)
  );

  tbt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_head          (head),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_tangent_x   (out_tangent_x),
    .out_tangent_y   (out_tangent_y),
    .out_tangent_z   (out_tangent_z),
    .out_bitangent_x (out_bitangent_x),
    .out_bitangent_y (out_bitangent_y),
    .out_bitangent_z (out_bitangent_z),
    .out_degenerate  (out_degenerate)
  );

endmodule

// ===== rtl/core/tbt_checker.sv =====
// Port-level checks for triangle_tangent_bitangent_core, bound to the top.
// Depends on tbt_pkg for the port widths.
module tbt_checker import tbt_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_push,
  input logic                    in_full,
  input logic                    in_first_of_mesh,
  input logic signed [POS_W-1:0] in_pos_x,
  input logic signed [POS_W-1:0] in_pos_y,
  input logic signed [POS_W-1:0] in_pos_z,
  input logic signed [UV_W-1:0]  in_tex_u,
  input logic signed [UV_W-1:0]  in_tex_v,
  input logic                    out_empty,
  input logic                    out_pop,
  input logic signed [POS_W-1:0] out_tangent_x,
  input logic signed [POS_W-1:0] out_tangent_y,
  input logic signed [POS_W-1:0] out_tangent_z,
  input logic signed [POS_W-1:0] out_bitangent_x,
  input logic signed [POS_W-1:0] out_bitangent_y,
  input logic signed [POS_W-1:0] out_bitangent_z,
  input logic                    out_degenerate
);

  // A waiting result stays until it is popped.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty)
    else $error("result vanished without a pop");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> $stable(out_tangent_x) && $stable(out_bitangent_z)
                               && $stable(out_degenerate))
    else $error("stalled result changed");

  // A zero determinant must come with all six vector fields at zero.
  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_degenerate |->
      out_tangent_x == '0 && out_tangent_y == '0 && out_tangent_z == '0 &&
      out_bitangent_x == '0 && out_bitangent_y == '0 && out_bitangent_z == '0)
    else $error("degenerate result with nonzero vectors");

  // Reset leaves no result pending and room for input.
  a_reset_clears: assert property (@(posedge clk)
    $past(!rst_n) |-> out_empty && !in_full)
    else $error("block not empty after reset");

endmodule

bind triangle_tangent_bitangent_core tbt_checker u_tbt_checker (.*);
